@@ sv/spr_pkg.sv @@
// Package for the swirl point remapper: widths, pipeline structs and constant tables.
// Used by every cell module and by the top level; depends on nothing.
package spr_pkg;

  localparam int COORD_BITS  = 12;
  localparam int FRAC_BITS   = 4;
  localparam int TRIG_STAGES = 16;

  localparam int PIX_W      = 12;
  localparam int MAP_BITS   = 19;
  localparam int DW         = COORD_BITS + 1;   // centre-relative offset
  localparam int RB         = COORD_BITS + 1;   // integer distance
  localparam int RW         = 2 * RB + 1;       // square-root remainder
  localparam int SQ_IDX_W   = $clog2(RB);
  localparam int TAYLOR_N   = 12;
  localparam int CW         = 34;               // CORDIC magnitude
  localparam int ZW         = 33;               // CORDIC angle
  localparam int CORDIC_IDX_W = 5;

  localparam int LATENCY = 2 + RB + 4 + 3 * TAYLOR_N + 4 + TRIG_STAGES + 3;

  localparam logic [2:0] REG_CENTER_X = 3'd0;
  localparam logic [2:0] REG_CENTER_Y = 3'd1;
  localparam logic [2:0] REG_RADIUS   = 3'd2;
  localparam logic [2:0] REG_GAIN     = 3'd3;
  localparam logic [2:0] REG_DECAY    = 3'd4;

  // Per-pixel data that travels the whole chain
  typedef struct packed {
    logic                   vld;
    logic                   in_rad;
    logic [COORD_BITS-1:0]  px;
    logic [COORD_BITS-1:0]  py;
    logic signed [DW-1:0]   dx;
    logic signed [DW-1:0]   dy;
  } spr_carry_t;

  typedef struct packed {
    spr_carry_t    c;
    logic [RW-1:0] rem;
    logic [RB-1:0] root;
  } spr_sqrt_t;

  typedef struct packed {
    spr_carry_t         c;
    logic [29:0]        t;
    logic signed [5:0]  ip;
    logic [30:0]        term;
    logic [31:0]        sum;
  } spr_exp_t;

  typedef struct packed {
    spr_carry_t           c;
    logic [1:0]           quad;
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic signed [ZW-1:0] z;
  } spr_cordic_t;

  // floor((2^32 - 1) / n): quotient estimate is exact or one short
  function automatic logic [31:0] recip_q32(input logic [3:0] n);
    logic [31:0] r;
    unique case (n)
      4'd1:    r = 32'd4294967295;
      4'd2:    r = 32'd2147483647;
      4'd3:    r = 32'd1431655765;
      4'd4:    r = 32'd1073741823;
      4'd5:    r = 32'd858993459;
      4'd6:    r = 32'd715827882;
      4'd7:    r = 32'd613566756;
      4'd8:    r = 32'd536870911;
      4'd9:    r = 32'd477218588;
      4'd10:   r = 32'd429496729;
      4'd11:   r = 32'd390451572;
      4'd12:   r = 32'd357913941;
      default: r = 32'd0;
    endcase
    return r;
  endfunction

  // atan(2^-i) as a fraction of a turn, 2^32 per turn
  function automatic logic [29:0] atan_turn(input logic [4:0] i);
    logic [29:0] a;
    unique case (i)
      5'd0:    a = 30'h20000000;
      5'd1:    a = 30'h12E4051E;
      5'd2:    a = 30'h09FB385B;
      5'd3:    a = 30'h051111D4;
      5'd4:    a = 30'h028B0D43;
      5'd5:    a = 30'h0145D7E1;
      5'd6:    a = 30'h00A2F61E;
      5'd7:    a = 30'h00517C55;
      5'd8:    a = 30'h0028BE53;
      5'd9:    a = 30'h00145F2F;
      5'd10:   a = 30'h000A2F98;
      5'd11:   a = 30'h000517CC;
      5'd12:   a = 30'h00028BE6;
      5'd13:   a = 30'h000145F3;
      5'd14:   a = 30'h0000A2FA;
      5'd15:   a = 30'h0000517D;
      5'd16:   a = 30'h000028BE;
      5'd17:   a = 30'h0000145F;
      5'd18:   a = 30'h00000A30;
      5'd19:   a = 30'h00000518;
      5'd20:   a = 30'h0000028C;
      5'd21:   a = 30'h00000146;
      5'd22:   a = 30'h000000A3;
      5'd23:   a = 30'h00000051;
      default: a = 30'h0;
    endcase
    return a;
  endfunction

endpackage

@@ sv/spr_sqrt_cell.sv @@
// One bit of the pipelined integer square root (restoring, one result bit per cell).
// Depends on spr_pkg.
module spr_sqrt_cell (
  input  logic                          clk,
  input  logic                          rst,
  input  logic [spr_pkg::SQ_IDX_W-1:0]  bit_idx,
  input  spr_pkg::spr_sqrt_t            din,
  output spr_pkg::spr_sqrt_t            dout
);

  logic [spr_pkg::RW-1:0] trial;
  spr_pkg::spr_sqrt_t     nxt;

  // Try setting this root bit against the remainder
  always_comb begin
    trial = (spr_pkg::RW'(din.root) << ({1'b0, bit_idx} + 1'b1))
          + (spr_pkg::RW'(1) << {bit_idx, 1'b0});
    nxt = din;
    if (din.rem >= trial) begin
      nxt.rem  = din.rem - trial;
      nxt.root = din.root | (spr_pkg::RB'(1) << bit_idx);
    end
  end

  // Advance to the next cell
  always_ff @(posedge clk) begin
    if (rst) begin
      dout.c.vld <= 1'b0;
    end else begin
      dout <= nxt;
    end
  end

endmodule

@@ sv/spr_exp_cell.sv @@
// One Taylor term of exp: term = (term * t >> 30) / n, accumulated into sum.
// Three register stages; depends on spr_pkg.
module spr_exp_cell (
  input  logic              clk,
  input  logic              rst,
  input  logic [3:0]        n,
  input  spr_pkg::spr_exp_t din,
  output spr_pkg::spr_exp_t dout
);

  spr_pkg::spr_exp_t a_e, b_e, nxt;
  logic [60:0]       a_p;
  logic [30:0]       b_quo;
  logic [62:0]       b_m;
  logic [30:0]       est, rem, est_fix;

  // Correct the reciprocal estimate by one where it fell short
  always_comb begin
    est      = b_m[62:32];
    rem      = b_quo - est * 31'(n);
    est_fix  = (rem >= 31'(n)) ? est + 31'd1 : est;
    nxt      = b_e;
    nxt.term = est_fix;
    nxt.sum  = b_e.sum + 32'(est_fix);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_e.c.vld  <= 1'b0;
      b_e.c.vld  <= 1'b0;
      dout.c.vld <= 1'b0;
    end else begin
      // multiply term by t
      a_e <= din;
      a_p <= din.term * din.t;
      // scale and multiply by 1/n
      b_e   <= a_e;
      b_quo <= a_p[60:30];
      b_m   <= a_p[60:30] * spr_pkg::recip_q32(n);
      // hand on the new term and running sum
      dout  <= nxt;
    end
  end

endmodule

@@ sv/spr_cordic_cell.sv @@
// One rotation step of the CORDIC sine/cosine chain on a 32-bit turn angle.
// Depends on spr_pkg for the arctangent table and the struct.
module spr_cordic_cell (
  input  logic                              clk,
  input  logic                              rst,
  input  logic [spr_pkg::CORDIC_IDX_W-1:0]  idx,
  input  spr_pkg::spr_cordic_t              din,
  output spr_pkg::spr_cordic_t              dout
);

  logic signed [spr_pkg::CW-1:0] sx, sy;
  logic signed [spr_pkg::ZW-1:0] at;
  spr_pkg::spr_cordic_t          nxt;

  // Rotate towards zero residual angle
  always_comb begin
    sx  = din.x >>> idx;
    sy  = din.y >>> idx;
    at  = $signed(spr_pkg::ZW'(spr_pkg::atan_turn(idx)));
    nxt = din;
    if (!din.z[spr_pkg::ZW-1]) begin
      nxt.x = din.x - sy;
      nxt.y = din.y + sx;
      nxt.z = din.z - at;
    end else begin
      nxt.x = din.x + sy;
      nxt.y = din.y - sx;
      nxt.z = din.z + at;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dout.c.vld <= 1'b0;
    end else begin
      dout <= nxt;
    end
  end

endmodule

@@ sv/swirl_point_remap.sv @@
// Throughput: one transaction per cycle; busy stays low, start is taken every cycle.
// Most of the pipeline lies in the square-root, Taylor and CORDIC cell chains.
// Reset (rst, synchronous) empties the pipeline and clears all configuration to zero.
// done marks each result for exactly one cycle; the receiver cannot stall.
// Top level of the swirl point remapper; uses spr_pkg and the three cell modules.
module swirl_point_remap (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  output logic                                busy,
  input  logic [spr_pkg::PIX_W-1:0]           pix_x,
  input  logic [spr_pkg::PIX_W-1:0]           pix_y,
  input  logic                                cfg_we,
  input  logic [2:0]                          cfg_idx,
  input  logic [23:0]                         cfg_data,
  output logic                                done,
  output logic signed [spr_pkg::MAP_BITS-1:0] map_x,
  output logic signed [spr_pkg::MAP_BITS-1:0] map_y,
  output logic                                rotated
);

  localparam int SH = 15 - spr_pkg::FRAC_BITS;
  localparam int PW = spr_pkg::DW + 16;
  localparam int MW = PW + 2;
  localparam logic signed [37:0] E_LIM = 38'sd12582912;
  localparam logic signed [MW-1:0] RND = MW'(1) << (SH - 1);
  localparam logic signed [MW-1:0] MAP_HI = MW'((1 << (spr_pkg::MAP_BITS - 1)) - 1);
  localparam logic signed [MW-1:0] MAP_LO = -MAP_HI - MW'(1);

  // configuration registers
  logic [spr_pkg::COORD_BITS-1:0] cx, cy;
  logic [12:0]                    radius;
  logic signed [23:0]             gain, decay;

  // pipeline registers
  spr_pkg::spr_carry_t s0, e0c, e1c, e2c, e4c, e5c, e6c, qc, m1c;
  spr_pkg::spr_sqrt_t  s1;
  spr_pkg::spr_exp_t   e3;
  spr_pkg::spr_cordic_t e7;
  logic signed [37:0]  e0_e;
  logic signed [24:0]  e1_ec;
  logic signed [25:0]  e2_y;
  logic [31:0]         e4_v;
  logic signed [56:0]  e5_ang;
  logic signed [59:0]  e6_ph;
  logic [57:0]         e6_pl;
  logic signed [15:0]  q_c, q_s;
  logic signed [PW-1:0] p_xc, p_ys, p_xs, p_yc;

  spr_pkg::spr_sqrt_t   sq_ch [spr_pkg::RB+1];
  spr_pkg::spr_exp_t    ex_ch [spr_pkg::TAYLOR_N+1];
  spr_pkg::spr_cordic_t co_ch [spr_pkg::TRIG_STAGES+1];

  assign busy = 1'b0;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      cx <= '0; cy <= '0; radius <= '0; gain <= '0; decay <= '0;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        spr_pkg::REG_CENTER_X: cx     <= cfg_data[spr_pkg::COORD_BITS-1:0];
        spr_pkg::REG_CENTER_Y: cy     <= cfg_data[spr_pkg::COORD_BITS-1:0];
        spr_pkg::REG_RADIUS:   radius <= cfg_data[12:0];
        spr_pkg::REG_GAIN:     gain   <= $signed(cfg_data);
        spr_pkg::REG_DECAY:    decay  <= $signed(cfg_data);
        default: ;
      endcase
    end
  end

  // Front: offsets and squared distance
  logic [spr_pkg::COORD_BITS-1:0]   px_in, py_in;
  logic signed [2*spr_pkg::DW-1:0]  sqx, sqy;
  always_comb begin
    px_in = pix_x[spr_pkg::COORD_BITS-1:0];
    py_in = pix_y[spr_pkg::COORD_BITS-1:0];
    sqx   = s0.dx * s0.dx;
    sqy   = s0.dy * s0.dy;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s0.vld   <= 1'b0;
      s1.c.vld <= 1'b0;
    end else begin
      s0.vld    <= start & ~busy;
      s0.in_rad <= 1'b0;
      s0.px     <= px_in;
      s0.py     <= py_in;
      s0.dx     <= $signed({1'b0, px_in}) - $signed({1'b0, cx});
      s0.dy     <= $signed({1'b0, py_in}) - $signed({1'b0, cy});
      s1.c      <= s0;
      s1.rem    <= spr_pkg::RW'($unsigned(sqx)) + spr_pkg::RW'($unsigned(sqy));
      s1.root   <= '0;
    end
  end

  // Square-root chain
  assign sq_ch[0] = s1;
  for (genvar g = 0; g < spr_pkg::RB; g++) begin : g_sqrt
    spr_sqrt_cell u_cell (
      .clk(clk), .rst(rst),
      .bit_idx(spr_pkg::SQ_IDX_W'(spr_pkg::RB - 1 - g)),
      .din(sq_ch[g]), .dout(sq_ch[g+1])
    );
  end

  // Exponent argument, clamp, base-2 split
  spr_pkg::spr_carry_t sq_o;
  logic signed [56:0] ylog;
  logic signed [49:0] tprod;
  always_comb begin
    sq_o        = sq_ch[spr_pkg::RB].c;
    sq_o.in_rad = (13'(sq_ch[spr_pkg::RB].root) <= radius);
    ylog  = e1_ec * 57'sd1549082005;
    tprod = $signed({1'b0, e2_y[19:0]} * 50'd744261118);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      e0c.vld <= 1'b0; e1c.vld <= 1'b0; e2c.vld <= 1'b0; e3.c.vld <= 1'b0;
    end else begin
      e0c        <= sq_o;
      e0_e       <= decay * $signed({1'b0, sq_ch[spr_pkg::RB].root});
      e1c        <= e0c;
      if (e0_e > E_LIM)       e1_ec <= 25'(E_LIM);
      else if (e0_e < -E_LIM) e1_ec <= 25'(-E_LIM);
      else                    e1_ec <= 25'(e0_e);
      e2c        <= e1c;
      e2_y       <= 26'(ylog >>> 30);
      e3.c       <= e2c;
      e3.ip      <= 6'(e2_y >>> 20);
      e3.t       <= tprod[49:20];
      e3.term    <= 31'h40000000;
      e3.sum     <= 32'h40000000;
    end
  end

  // Taylor chain
  assign ex_ch[0] = e3;
  for (genvar g = 0; g < spr_pkg::TAYLOR_N; g++) begin : g_exp
    spr_exp_cell u_cell (
      .clk(clk), .rst(rst), .n(4'(g + 1)),
      .din(ex_ch[g]), .dout(ex_ch[g+1])
    );
  end

  // Power-of-two scale, angle, phase
  spr_pkg::spr_exp_t ex_o;
  logic [6:0]  lsh, rsh;
  logic [35:0] scaled;
  logic [63:0] ph_sum;
  always_comb begin
    ex_o   = ex_ch[spr_pkg::TAYLOR_N];
    lsh    = 7'(ex_o.ip) - 7'd14;
    rsh    = 7'd14 - 7'(ex_o.ip);
    if (ex_o.ip >= 6'sd14) scaled = {4'b0, ex_o.sum} << lsh;
    else                   scaled = {4'b0, ex_o.sum} >> rsh;
    ph_sum = ({{4{e6_ph[59]}}, e6_ph} << 28) + {6'b0, e6_pl};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      e4c.vld <= 1'b0; e5c.vld <= 1'b0; e6c.vld <= 1'b0; e7.c.vld <= 1'b0;
    end else begin
      e4c    <= ex_o.c;
      e4_v   <= (scaled[35:32] != 4'd0) ? 32'hFFFFFFFF : scaled[31:0];
      e5c    <= e4c;
      e5_ang <= gain * $signed({1'b0, e4_v});
      e6c    <= e5c;
      e6_ph  <= $signed(e5_ang[56:28]) * 60'sd683565276;
      e6_pl  <= e5_ang[27:0] * 58'd683565276;
      e7.c   <= e6c;
      e7.quad <= ph_sum[63:62];
      e7.x   <= spr_pkg::CW'(652032874);
      e7.y   <= '0;
      e7.z   <= $signed({3'b0, ph_sum[61:48], 16'b0});
    end
  end

  // CORDIC chain
  assign co_ch[0] = e7;
  for (genvar g = 0; g < spr_pkg::TRIG_STAGES; g++) begin : g_cordic
    spr_cordic_cell u_cell (
      .clk(clk), .rst(rst), .idx(spr_pkg::CORDIC_IDX_W'(g)),
      .din(co_ch[g]), .dout(co_ch[g+1])
    );
  end

  function automatic logic signed [15:0] to_q15(input logic signed [spr_pkg::CW-1:0] v);
    logic signed [spr_pkg::CW-1:0] r;
    r = (v + $signed(spr_pkg::CW'(16384))) >>> 15;
    if (r > $signed(spr_pkg::CW'(32767)))       return 16'sd32767;
    else if (r < -$signed(spr_pkg::CW'(32767))) return -16'sd32767;
    else                                        return r[15:0];
  endfunction

  function automatic logic signed [spr_pkg::MAP_BITS-1:0] sat_map(
      input logic signed [MW-1:0] v);
    if (v > MAP_HI)      return spr_pkg::MAP_BITS'(MAP_HI);
    else if (v < MAP_LO) return spr_pkg::MAP_BITS'(MAP_LO);
    else                 return v[spr_pkg::MAP_BITS-1:0];
  endfunction

  // Quadrant fold, rotation and rounding
  spr_pkg::spr_cordic_t co_o;
  logic signed [15:0]   cc, ss, c_q, s_q;
  logic signed [MW-1:0] mx, my, rx, ry;
  always_comb begin
    co_o = co_ch[spr_pkg::TRIG_STAGES];
    cc   = to_q15(co_o.x);
    ss   = to_q15(co_o.y);
    unique case (co_o.quad)
      2'd0: begin c_q = cc;  s_q = ss;  end
      2'd1: begin c_q = -ss; s_q = cc;  end
      2'd2: begin c_q = -cc; s_q = -ss; end
      default: begin c_q = ss; s_q = -cc; end
    endcase
    mx = MW'(p_xc) - MW'(p_ys) + $signed(MW'({cx, 15'b0}));
    my = MW'(p_xs) + MW'(p_yc) + $signed(MW'({cy, 15'b0}));
    rx = (mx + RND) >>> SH;
    ry = (my + RND) >>> SH;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      qc.vld  <= 1'b0;
      m1c.vld <= 1'b0;
      done    <= 1'b0;
    end else begin
      qc   <= co_o.c;
      q_c  <= c_q;
      q_s  <= s_q;
      m1c  <= qc;
      p_xc <= qc.dx * q_c;
      p_ys <= qc.dy * q_s;
      p_xs <= qc.dx * q_s;
      p_yc <= qc.dy * q_c;
      // drive the result for one cycle
      done    <= m1c.vld;
      rotated <= m1c.in_rad;
      if (m1c.in_rad) begin
        map_x <= sat_map(rx);
        map_y <= sat_map(ry);
      end else begin
        map_x <= spr_pkg::MAP_BITS'(m1c.px) << spr_pkg::FRAC_BITS;
        map_y <= spr_pkg::MAP_BITS'(m1c.py) << spr_pkg::FRAC_BITS;
      end
    end
  end

`ifndef SYNTH
  // every accepted transaction comes out after the fixed latency
  a_latency: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##(spr_pkg::LATENCY) done)
    else $error("result missing after pipeline latency");

  // reset empties the pipeline
  a_reset_flush: assert property (@(posedge clk) rst |=> !done)
    else $error("result strobe right after reset");

  // a passed-through point is never negative
  a_bypass_sign: assert property (@(posedge clk) disable iff (rst)
    (done && !rotated) |-> (!map_x[spr_pkg::MAP_BITS-1] && !map_y[spr_pkg::MAP_BITS-1]))
    else $error("negative coordinate on pass-through point");
`endif

endmodule

@@ sim/testbench.sv @@
// Self-checking testbench for swirl_point_remap: directed and random pixels under several
// swirl settings, each result checked against an in-bench fixed-point remap predictor.
// Depends on spr_pkg and the swirl_point_remap RTL.
module testbench;

  typedef struct {
    logic signed [spr_pkg::MAP_BITS-1:0] mx;
    logic signed [spr_pkg::MAP_BITS-1:0] my;
    logic                                rot;
  } remap_t;

  localparam longint LOG2E_Q30    = 64'd1549082005;
  localparam longint LN2_Q30      = 64'd744261118;
  localparam longint TURN_PER_RAD = 64'd683565276;
  localparam longint TRIG_GAIN    = 64'd652032874;
  localparam int     WATCH_LIMIT  = 4000;

  localparam longint ATAN_TURNS [24] = '{
    'h20000000, 'h12E4051E, 'h09FB385B, 'h051111D4, 'h028B0D43, 'h0145D7E1,
    'h00A2F61E, 'h00517C55, 'h0028BE53, 'h00145F2F, 'h000A2F98, 'h000517CC,
    'h00028BE6, 'h000145F3, 'h0000A2FA, 'h0000517D, 'h000028BE, 'h0000145F,
    'h00000A30, 'h00000518, 'h0000028C, 'h00000146, 'h000000A3, 'h00000051};

  logic                                clk = 1'b0;
  logic                                rst = 1'b1;
  logic                                start = 1'b0;
  logic                                busy;
  logic [spr_pkg::PIX_W-1:0]           pix_x = '0;
  logic [spr_pkg::PIX_W-1:0]           pix_y = '0;
  logic                                cfg_we = 1'b0;
  logic [2:0]                          cfg_idx = spr_pkg::REG_CENTER_X;
  logic [23:0]                         cfg_data = '0;
  logic                                done;
  logic signed [spr_pkg::MAP_BITS-1:0] map_x;
  logic signed [spr_pkg::MAP_BITS-1:0] map_y;
  logic                                rotated;

  // Predictor copy of the swirl settings
  longint swirl_cx, swirl_cy, swirl_rad, swirl_gain, swirl_decay;

  remap_t expected_maps[$];
  int     fail_count = 0;
  int     idle_count = 0;
  int     burst_left = 0;

  swirl_point_remap u_top (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .pix_x(pix_x), .pix_y(pix_y),
    .cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_data(cfg_data), .done(done),
    .map_x(map_x), .map_y(map_y), .rotated(rotated)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic longint int_sqrt(longint v);
    longint res, bitv;
    res = 0;
    bitv = 64'd1 << 30;
    while (bitv > v) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v = v - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  function automatic longint round_q15(longint v);
    longint r;
    r = (v + (64'sd1 <<< 14)) >>> 15;
    if (r > 32767) r = 32767;
    if (r < -32767) r = -32767;
    return r;
  endfunction

  function automatic logic signed [spr_pkg::MAP_BITS-1:0] clamp_map(longint v);
    longint hi;
    hi = (64'sd1 <<< (spr_pkg::MAP_BITS - 1)) - 1;
    if (v > hi) v = hi;
    if (v < -hi - 1) v = -hi - 1;
    return v[spr_pkg::MAP_BITS-1:0];
  endfunction

  // Work out the source coordinate of one destination pixel
  function automatic remap_t predict_remap(logic [spr_pkg::PIX_W-1:0] x,
                                           logic [spr_pkg::PIX_W-1:0] y);
    longint dx, dy, radial, e, yv, ip, fp, angle, xc, yc, zc, nx, ny, cc, ss, co, si;
    longint mxv, myv;
    logic [63:0] t, term, sum, ev, prod;
    logic [15:0] phase;
    remap_t res;
    dx = longint'(x) - swirl_cx;
    dy = longint'(y) - swirl_cy;
    radial = int_sqrt(dx * dx + dy * dy);
    if (radial > swirl_rad) begin
      res.mx = clamp_map(longint'(x) <<< spr_pkg::FRAC_BITS);
      res.my = clamp_map(longint'(y) <<< spr_pkg::FRAC_BITS);
      res.rot = 1'b0;
      return res;
    end
    // exp of the decay exponent, clamped to +-12
    e = swirl_decay * radial;
    if (e > (64'sd12 <<< 20)) e = 64'sd12 <<< 20;
    if (e < -(64'sd12 <<< 20)) e = -(64'sd12 <<< 20);
    yv = (e * LOG2E_Q30) >>> 30;
    ip = yv >>> 20;
    fp = yv - (ip <<< 20);
    t = (fp * LN2_Q30) >> 20;
    sum = 64'd1 << 30;
    term = 64'd1 << 30;
    for (int n = 1; n <= 12; n++) begin
      term = ((term * t) >> 30) / n;
      sum = sum + term;
    end
    if (ip >= 14) ev = sum << (ip - 14);
    else ev = sum >> (14 - ip);
    if (ev > 64'hFFFF_FFFF) ev = 64'hFFFF_FFFF;
    // angle to turn phase, modulo 2^64
    angle = swirl_gain * longint'(ev);
    prod = angle * TURN_PER_RAD;
    phase = prod[63:48];
    // rotate within one quadrant
    xc = TRIG_GAIN;
    yc = 0;
    zc = longint'({phase[13:0], 16'b0});
    for (int i = 0; i < spr_pkg::TRIG_STAGES && i < 24; i++) begin
      if (zc >= 0) begin
        nx = xc - (yc >>> i);
        ny = yc + (xc >>> i);
        zc = zc - ATAN_TURNS[i];
      end else begin
        nx = xc + (yc >>> i);
        ny = yc - (xc >>> i);
        zc = zc + ATAN_TURNS[i];
      end
      xc = nx;
      yc = ny;
    end
    cc = round_q15(xc);
    ss = round_q15(yc);
    case (phase[15:14])
      2'd0: begin co = cc;  si = ss;  end
      2'd1: begin co = -ss; si = cc;  end
      2'd2: begin co = -cc; si = -ss; end
      default: begin co = ss; si = -cc; end
    endcase
    mxv = dx * co - dy * si + (swirl_cx <<< 15);
    myv = dx * si + dy * co + (swirl_cy <<< 15);
    res.mx = clamp_map((mxv + (64'sd1 <<< (14 - spr_pkg::FRAC_BITS)))
                       >>> (15 - spr_pkg::FRAC_BITS));
    res.my = clamp_map((myv + (64'sd1 <<< (14 - spr_pkg::FRAC_BITS)))
                       >>> (15 - spr_pkg::FRAC_BITS));
    res.rot = 1'b1;
    return res;
  endfunction

  // Check each result against the oldest expectation
  always @(posedge clk) begin
    remap_t exp_map;
    if (!rst && done) begin
      if (expected_maps.size() == 0) begin
        $error("result with no transaction outstanding");
        fail_count++;
      end else begin
        exp_map = expected_maps.pop_front();
        if (map_x !== exp_map.mx) begin
          $error("map_x expected %0d actual %0d", exp_map.mx, map_x);
          fail_count++;
        end
        if (map_y !== exp_map.my) begin
          $error("map_y expected %0d actual %0d", exp_map.my, map_y);
          fail_count++;
        end
        if (rotated !== exp_map.rot) begin
          $error("rotated expected %0d actual %0d", exp_map.rot, rotated);
          fail_count++;
        end
      end
    end
  end

  // Watchdog: count cycles with no transaction in either direction
  always @(posedge clk) begin
    if (rst || done || (start && !busy)) begin
      idle_count <= 0;
    end else if (idle_count >= WATCH_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end else begin
      idle_count <= idle_count + 1;
    end
  end

  // Send one pixel; the sender works in bursts with random gaps
  task automatic send_pixel(input logic [spr_pkg::PIX_W-1:0] x,
                            input logic [spr_pkg::PIX_W-1:0] y);
    if (burst_left == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
      burst_left = $urandom_range(1, 20);
    end
    burst_left--;
    start <= 1'b1;
    pix_x <= x;
    pix_y <= y;
    do @(posedge clk); while (busy);
    expected_maps.push_back(predict_remap(x, y));
  endtask

  // Hold off until every result is back, then let the pipeline empty
  task automatic drain_pipeline();
    start <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (expected_maps.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Write all five registers with the pipeline idle; unused data bits are random
  task automatic set_swirl(input longint cx, input longint cy, input longint rad,
                           input longint gain, input longint decay);
    logic [23:0] vals [5];
    logic [2:0]  idxs [5];
    drain_pipeline();
    vals[0] = {12'($urandom_range(0, 4095)), cx[11:0]};
    vals[1] = {12'($urandom_range(0, 2047)), cy[11:0]};
    vals[2] = {11'($urandom_range(0, 2047)), rad[12:0]};
    vals[3] = gain[23:0];
    vals[4] = decay[23:0];
    idxs = '{spr_pkg::REG_CENTER_X, spr_pkg::REG_CENTER_Y, spr_pkg::REG_RADIUS,
             spr_pkg::REG_GAIN, spr_pkg::REG_DECAY};
    for (int i = 0; i < 5; i++) begin
      cfg_we <= 1'b1;
      cfg_idx <= idxs[i];
      cfg_data <= vals[i];
      @(posedge clk);
    end
    cfg_we <= 1'b0;
    swirl_cx = cx[11:0];
    swirl_cy = cy[11:0];
    swirl_rad = rad[12:0];
    swirl_gain = longint'(signed'(gain[23:0]));
    swirl_decay = longint'(signed'(decay[23:0]));
  endtask

  function automatic logic [spr_pkg::PIX_W-1:0] near_centre(longint c, longint rad);
    longint v;
    v = c + longint'($urandom_range(0, 2 * rad + 2)) - rad - 1;
    if (v < 0) v = 0;
    if (v > 4095) v = 4095;
    return v[spr_pkg::PIX_W-1:0];
  endfunction

  // Reset settings: only the origin lies within the zero radius
  task automatic test_reset_state();
    send_pixel(12'd0, 12'd0);
    send_pixel(12'd1, 12'd0);
    send_pixel(12'hFFF, 12'hFFF);
  endtask

  // Field extremes with a radius that covers the whole image
  task automatic test_field_extremes();
    set_swirl(2048, 2048, 5793, 24'h7FFFFF, 24'h000100);
    send_pixel(12'd0, 12'd0);
    send_pixel(12'hFFF, 12'd0);
    send_pixel(12'd0, 12'hFFF);
    send_pixel(12'hFFF, 12'hFFF);
    send_pixel(12'd2048, 12'd2048);
    send_pixel(12'hAAA, 12'h555);
    set_swirl(4095, 0, 5793, 24'h800000, 24'h800000);
    send_pixel(12'd0, 12'hFFF);
    send_pixel(12'hFFF, 12'd0);
    send_pixel(12'h555, 12'hAAA);
  endtask

  // Zero radius: only the centre rotates, and it lands on itself
  task automatic test_zero_radius();
    set_swirl(1000, 3000, 0, 24'h123456, 24'h000000);
    send_pixel(12'd1000, 12'd3000);
    send_pixel(12'd1001, 12'd3000);
    send_pixel(12'd1000, 12'd2999);
  endtask

  // Large exponent: exp saturates; also the boundary distance either side
  task automatic test_large_exponent();
    set_swirl(100, 100, 50, 24'h7FFFFF, 24'h7FFFFF);
    send_pixel(12'd130, 12'd140);
    send_pixel(12'd150, 12'd100);
    send_pixel(12'd151, 12'd100);
    send_pixel(12'd50, 12'd100);
    set_swirl(100, 100, 50, 24'hFFFFFF, 24'h7FFFFF);
    send_pixel(12'd120, 12'd90);
    send_pixel(12'd100, 12'd150);
  endtask

  // Random settings, mostly pixels close to the centre so rotation is exercised
  task automatic test_random_swirls();
    longint cx, cy, rad, gain, decay;
    for (int ph = 0; ph < 11; ph++) begin
      cx = $urandom_range(0, 4095);
      cy = $urandom_range(0, 4095);
      case (ph % 4)
        0: rad = $urandom_range(0, 64);
        1: rad = $urandom_range(0, 5793);
        2: rad = 5793;
        default: rad = $urandom_range(0, 600);
      endcase
      gain = longint'($urandom_range(0, 24'hFFFFFF));
      if (ph % 3 == 0) decay = longint'($urandom_range(0, 24'hFFFFFF));
      else decay = longint'($urandom_range(0, 8191)) - 4096;
      set_swirl(cx, cy, rad, gain, decay);
      for (int k = 0; k < 50; k++) begin
        if ($urandom_range(0, 3) != 0)
          send_pixel(near_centre(cx, rad), near_centre(cy, rad));
        else
          send_pixel(12'($urandom), 12'($urandom));
      end
    end
  endtask

  initial begin
    swirl_cx = 0;
    swirl_cy = 0;
    swirl_rad = 0;
    swirl_gain = 0;
    swirl_decay = 0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    test_reset_state();
    test_field_extremes();
    test_zero_radius();
    test_large_exponent();
    test_random_swirls();
    drain_pipeline();
    repeat (spr_pkg::LATENCY + 10) @(posedge clk);
    if (fail_count == 0 && expected_maps.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

@@ files.f @@
sv/spr_pkg.sv
sv/spr_sqrt_cell.sv
sv/spr_exp_cell.sv
sv/spr_cordic_cell.sv
sv/swirl_point_remap.sv
sim/testbench.sv
